### hdl/apt_pkg.sv
// shared types and constants for the actuator position tracker
package apt_pkg;

	localparam int POSITION_WIDTH_DEF = 32;

	localparam int CMD_W      = 2;
	localparam int DELTA_W    = 16;
	localparam int SCALE_W    = 24;
	localparam int STROKE_W   = 31;
	localparam int BOUND_W    = 32;
	localparam int POS_OUT_W  = 32;
	localparam int INC_W      = 32;
	localparam int FRAC_SHIFT = 8;
	localparam int PROD_W     = DELTA_W + SCALE_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_PULSE     = 2'd0,
		CMD_MIN_LIMIT = 2'd1,
		CMD_MAX_LIMIT = 2'd2,
		CMD_NONE      = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MM_PER_PULSE = 3'd0,
		REG_STROKE       = 3'd1,
		REG_LOW_A        = 3'd2,
		REG_LOW_B        = 3'd3,
		REG_HIGH_C       = 3'd4,
		REG_HIGH_D       = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [SCALE_W-1:0]         mm_per_pulse;
		logic [STROKE_W-1:0]        stroke_length;
		logic signed [BOUND_W-1:0]  low_a;
		logic signed [BOUND_W-1:0]  low_b;
		logic signed [BOUND_W-1:0]  high_c;
		logic signed [BOUND_W-1:0]  high_d;
	} apt_cfg_t;

	typedef struct packed {
		logic signed [POS_OUT_W-1:0] position;
		logic                        is_calibrated;
		logic                        calibration_allowed;
		logic                        in_low_zone;
		logic                        in_high_zone;
		logic                        min_switch_active;
		logic                        max_switch_active;
		logic                        calibrated_now;
	} apt_result_t;

endpackage

### hdl/apt_core.sv
// position state, saturating accumulate, zone evaluation and homing
module apt_core
	import apt_pkg::*;
#(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  cmd_t                     cmd,
	input  logic signed [INC_W-1:0]  inc,
	input  logic                     level,
	input  apt_cfg_t                 cfg,
	output apt_result_t              res
);

	localparam int SW = ((POSITION_WIDTH > BOUND_W) ? POSITION_WIDTH : BOUND_W) + 1;

	localparam logic signed [SW-1:0] PMAX =
		{{(SW-POSITION_WIDTH+1){1'b0}}, {(POSITION_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] PMIN =
		{{(SW-POSITION_WIDTH+1){1'b1}}, {(POSITION_WIDTH-1){1'b0}}};
	localparam logic signed [SW-1:0] OMAX = {{(SW-POS_OUT_W+1){1'b0}}, {(POS_OUT_W-1){1'b1}}};
	localparam logic signed [SW-1:0] OMIN = {{(SW-POS_OUT_W+1){1'b1}}, {(POS_OUT_W-1){1'b0}}};

	logic signed [POSITION_WIDTH-1:0] pos_q;
	logic calibrated_q;
	logic allowed_q;
	logic low_zone_q;
	logic high_zone_q;
	logic min_sw_q;
	logic max_sw_q;

	logic signed [SW-1:0] pos_ext;
	logic signed [SW-1:0] inc_ext;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] sum_sat;
	logic signed [SW-1:0] stroke_ext;
	logic signed [SW-1:0] stroke_sat;
	logic signed [SW-1:0] a_ext;
	logic signed [SW-1:0] b_ext;
	logic signed [SW-1:0] c_ext;
	logic signed [SW-1:0] d_ext;
	logic signed [SW-1:0] pos_d_ext;
	logic signed [SW-1:0] out_sat;
	logic low_hit;
	logic high_hit;

	logic signed [POSITION_WIDTH-1:0] pos_d;
	logic calibrated_d;
	logic allowed_d;
	logic low_zone_d;
	logic high_zone_d;
	logic min_sw_d;
	logic max_sw_d;
	logic homed;

	assign pos_ext    = {{(SW-POSITION_WIDTH){pos_q[POSITION_WIDTH-1]}}, pos_q};
	assign inc_ext    = {{(SW-INC_W){inc[INC_W-1]}}, inc};
	assign sum        = pos_ext + inc_ext;
	assign sum_sat    = (sum > PMAX) ? PMAX : ((sum < PMIN) ? PMIN : sum);
	assign stroke_ext = {{(SW-STROKE_W){1'b0}}, cfg.stroke_length};
	assign stroke_sat = (stroke_ext > PMAX) ? PMAX : stroke_ext;
	assign a_ext      = {{(SW-BOUND_W){cfg.low_a[BOUND_W-1]}}, cfg.low_a};
	assign b_ext      = {{(SW-BOUND_W){cfg.low_b[BOUND_W-1]}}, cfg.low_b};
	assign c_ext      = {{(SW-BOUND_W){cfg.high_c[BOUND_W-1]}}, cfg.high_c};
	assign d_ext      = {{(SW-BOUND_W){cfg.high_d[BOUND_W-1]}}, cfg.high_d};

	// reversed or equal bounds fall back to a one-sided window
	assign low_hit  = (cfg.low_a < cfg.low_b) ? (sum_sat >= a_ext && sum_sat <= b_ext)
						  : (sum_sat <= a_ext);
	assign high_hit = (cfg.high_c > cfg.high_d) ? (sum_sat >= d_ext && sum_sat <= c_ext)
						    : (sum_sat >= c_ext);

	always_comb begin
		pos_d        = pos_q;
		calibrated_d = calibrated_q;
		allowed_d    = allowed_q;
		low_zone_d   = low_zone_q;
		high_zone_d  = high_zone_q;
		min_sw_d     = min_sw_q;
		max_sw_d     = max_sw_q;
		homed        = 1'b0;
		unique case (cmd)
			CMD_PULSE: begin
				pos_d       = sum_sat[POSITION_WIDTH-1:0];
				low_zone_d  = low_hit;
				high_zone_d = high_hit;
				allowed_d   = calibrated_q ? (low_hit || high_hit) : 1'b1;
			end
			CMD_MIN_LIMIT: begin
				min_sw_d = level;
				if (level && allowed_q) begin
					pos_d        = '0;
					calibrated_d = 1'b1;
					homed        = 1'b1;
				end
			end
			CMD_MAX_LIMIT: begin
				max_sw_d = level;
				if (level && allowed_q) begin
					pos_d        = stroke_sat[POSITION_WIDTH-1:0];
					calibrated_d = 1'b1;
					homed        = 1'b1;
				end
			end
			CMD_NONE: begin
				homed = 1'b0;
			end
		endcase
	end

	assign pos_d_ext = {{(SW-POSITION_WIDTH){pos_d[POSITION_WIDTH-1]}}, pos_d};
	assign out_sat   = (pos_d_ext > OMAX) ? OMAX : ((pos_d_ext < OMIN) ? OMIN : pos_d_ext);

	always_comb begin
		res.position            = out_sat[POS_OUT_W-1:0];
		res.is_calibrated       = calibrated_d;
		res.calibration_allowed = allowed_d;
		res.in_low_zone         = low_zone_d;
		res.in_high_zone        = high_zone_d;
		res.min_switch_active   = min_sw_d;
		res.max_switch_active   = max_sw_d;
		res.calibrated_now      = homed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			calibrated_q <= 1'b0;
			allowed_q    <= 1'b1;
			low_zone_q   <= 1'b0;
			high_zone_q  <= 1'b0;
			min_sw_q     <= 1'b0;
			max_sw_q     <= 1'b0;
		end else if (step) begin
			pos_q        <= pos_d;
			calibrated_q <= calibrated_d;
			allowed_q    <= allowed_d;
			low_zone_q   <= low_zone_d;
			high_zone_q  <= high_zone_d;
			min_sw_q     <= min_sw_d;
			max_sw_q     <= max_sw_d;
		end
	end

endmodule

### hdl/actuator_position_tracker_with_homing.sv
// top level of the actuator position tracker with limit homing
//
// Input stream s_t*: one transaction per hall pulse update or limit event.
// Output stream m_t*: exactly one result transaction per input transaction,
// in order, showing position and flags after that item.
// Config channel cfg_*: register writes, always ready, to be used only while
// no item is in flight.
// Pipeline: three registers in the path: an input register, a register after
// the pulse scaling multiplier, and the result register loaded by the
// accumulate, clamp and zone compare logic.
// Throughput: one item per cycle unless a low m_tready stalls the pipe; the
// position state is updated in the same cycle that the result register loads,
// so consecutive items chain directly.
// Stall: when m_tready is low with a result held, the whole pipe freezes and
// s_tready drops; nothing is lost or repeated.
// Reset: position 0, not calibrated, calibration allowed, all other flags 0,
// all config registers 0, pipe empty.
module actuator_position_tracker_with_homing
	import apt_pkg::*;
#(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// cmd[1:0], pulse_delta[17:2], switch_level[18], zero pad
	input  logic [S_DATA_W-1:0]    s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// position[31:0], is_calibrated[32], calibration_allowed[33], in_low_zone[34],
	// in_high_zone[35], min_switch_active[36], max_switch_active[37],
	// calibrated_now[38], zero pad
	output logic [M_DATA_W-1:0]    m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	apt_cfg_t cfg_q;

	logic                        valid_s1;
	cmd_t                        cmd_s1;
	logic signed [DELTA_W-1:0]   delta_s1;
	logic                        level_s1;

	logic                        valid_s2;
	cmd_t                        cmd_s2;
	logic signed [INC_W-1:0]     inc_s2;
	logic                        level_s2;

	logic                        out_valid_q;
	apt_result_t                 res_q;

	logic                        en;
	logic signed [PROD_W-1:0]    prod;
	apt_result_t                 res;

	assign en        = !out_valid_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MM_PER_PULSE: cfg_q.mm_per_pulse  <= cfg_data[SCALE_W-1:0];
				REG_STROKE:       cfg_q.stroke_length <= cfg_data[STROKE_W-1:0];
				REG_LOW_A:        cfg_q.low_a         <= cfg_data[BOUND_W-1:0];
				REG_LOW_B:        cfg_q.low_b         <= cfg_data[BOUND_W-1:0];
				REG_HIGH_C:       cfg_q.high_c        <= cfg_data[BOUND_W-1:0];
				REG_HIGH_D:       cfg_q.high_d        <= cfg_data[BOUND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// q16.8 scale times signed pulses, arithmetic shift gives floor
	assign prod = delta_s1 * $signed({1'b0, cfg_q.mm_per_pulse});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= s_tvalid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && s_tvalid) begin
			cmd_s1   <= cmd_t'(s_tdata[CMD_W-1:0]);
			delta_s1 <= s_tdata[CMD_W+DELTA_W-1:CMD_W];
			level_s1 <= s_tdata[CMD_W+DELTA_W];
		end
		if (en && valid_s1) begin
			cmd_s2   <= cmd_s1;
			inc_s2   <= prod[FRAC_SHIFT+INC_W-1:FRAC_SHIFT];
			level_s2 <= level_s1;
		end
		if (en && valid_s2) begin
			res_q <= res;
		end
	end

	apt_core #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (en && valid_s2),
		.cmd    (cmd_s2),
		.inc    (inc_s2),
		.level  (level_s2),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0,
			   res_q.calibrated_now,
			   res_q.max_switch_active,
			   res_q.min_switch_active,
			   res_q.in_high_zone,
			   res_q.in_low_zone,
			   res_q.calibration_allowed,
			   res_q.is_calibrated,
			   res_q.position};

endmodule
